// ===== rtl/cesv_pkg.sv =====
// ----------------------------------------------------------------------------
// cesv_pkg
// Types and constants for the C escape sequence validator.
// ----------------------------------------------------------------------------
package cesv_pkg;

    localparam int unsigned MAX_BODY_LEN  = 4096;
    localparam int unsigned OFS_FIELD_MAX = 4095;
    localparam int unsigned POS_LIMIT_INT =
        (MAX_BODY_LEN - 1 > OFS_FIELD_MAX) ? OFS_FIELD_MAX : MAX_BODY_LEN - 1;
    localparam logic [11:0] POS_LIMIT     = 12'(POS_LIMIT_INT);

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LN     = 8'h6e;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic [3:0] UCN_SHORT_DIGITS = 4'd4;
    localparam logic [3:0] UCN_LONG_DIGITS  = 4'd8;
    localparam logic [3:0] OCT_MORE_DIGITS  = 4'd2;

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_BSLASH    = 3'd1,
        MODE_OCTAL     = 3'd2,
        MODE_HEX_FIRST = 3'd3,
        MODE_HEX_RUN   = 3'd4,
        MODE_UCN       = 3'd5,
        MODE_DONE      = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        CAT_TRAILING  = 3'd0,
        CAT_HEX_EMPTY = 3'd1,
        CAT_UCN_SHORT = 3'd2,
        CAT_UCN_BAD   = 3'd3,
        CAT_UNDEFINED = 3'd4
    } t_cat;

endpackage

// ===== rtl/c_escape_sequence_validator.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_validator
// Checks the escapes in a C literal body, at most one byte per item, and reports the
// first invalid escape, its category and the offset of its backslash.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | i_valid / o_stall  | i_char_in, i_last, i_no_char
//  result   | out       | o_valid / i_stall  | o_found, o_category, o_offset
//
//  one item per cycle, unless a body end waits on a stalled result; each item
//  is held in the input register, where the scan state is stepped, and a
//  body end loads the result register.
//  synchronous active-low reset clears the valid flags of both registers and the scan state.
//  a stalled result only holds back an item that ends a body.
// ----------------------------------------------------------------------------
module c_escape_sequence_validator
    import cesv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_last,
    input  logic        i_no_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [2:0]  o_category,
    output logic [11:0] o_offset
);

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic        r_no_char;

    t_mode       r_mode,   n_mode;
    logic [3:0]  r_digits, n_digits;
    logic        r_ucn_bad, n_ucn_bad;
    logic [11:0] r_pos,    n_pos;
    logic [11:0] r_esc,    n_esc;
    logic        r_seen,   n_seen;
    t_cat        r_kind,   n_kind;
    logic [11:0] r_vofs,   n_vofs;

    logic        r_out_valid;
    logic        r_found;
    logic [2:0]  r_cat;
    logic [11:0] r_ofs;

    logic        n_found;
    logic [2:0]  n_cat;
    logic [11:0] n_ofs;

    logic        ends_body;
    logic        out_free;
    logic        advance;
    logic        is_oct;
    logic        is_hex;
    logic        rec;
    t_cat        rec_kind;

    assign ends_body = r_last | r_no_char;
    assign out_free  = ~r_out_valid | ~i_stall;
    assign advance   = r_in_valid & (~ends_body | out_free);
    assign o_stall   = r_in_valid & ~advance;

    assign is_oct = (r_char inside {[CH_0:CH_7]});
    assign is_hex = (r_char inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]});

    always_comb begin
        n_mode    = r_mode;
        n_digits  = r_digits;
        n_ucn_bad = r_ucn_bad;
        n_pos     = r_pos;
        n_esc     = r_esc;
        n_seen    = r_seen;
        n_kind    = r_kind;
        n_vofs    = r_vofs;
        n_found   = 1'b0;
        n_cat     = 3'd0;
        n_ofs     = 12'd0;
        rec       = 1'b0;
        rec_kind  = CAT_TRAILING;

        if (!r_no_char) begin
            case (r_mode)
                MODE_NORMAL: begin
                    if (r_char == CH_BSLASH) begin
                        n_mode = MODE_BSLASH;
                        n_esc  = r_pos;
                    end
                end
                MODE_BSLASH: begin
                    if (r_char inside {CH_LN, CH_LT, CH_LV, CH_LB, CH_LR, CH_LF, CH_LA,
                                       CH_BSLASH, CH_QMARK, CH_SQUOTE, CH_DQUOTE}) begin
                        n_mode = MODE_NORMAL;
                    end else if (r_char == CH_LX) begin
                        n_mode = MODE_HEX_FIRST;
                    end else if (r_char == CH_LU || r_char == CH_UU) begin
                        n_mode    = MODE_UCN;
                        n_digits  = (r_char == CH_LU) ? UCN_SHORT_DIGITS : UCN_LONG_DIGITS;
                        n_ucn_bad = 1'b0;
                    end else if (is_oct) begin
                        n_mode   = MODE_OCTAL;
                        n_digits = OCT_MORE_DIGITS;
                    end else begin
                        rec      = 1'b1;
                        rec_kind = CAT_UNDEFINED;
                    end
                end
                MODE_OCTAL: begin
                    if (r_digits != 4'd0 && is_oct) begin
                        n_digits = r_digits - 4'd1;
                        if (r_digits == 4'd1) begin
                            n_mode = MODE_NORMAL;
                        end
                    end else begin
                        n_digits = 4'd0;
                        if (r_char == CH_BSLASH) begin
                            n_mode = MODE_BSLASH;
                            n_esc  = r_pos;
                        end else begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                end
                MODE_HEX_FIRST: begin
                    if (is_hex) begin
                        n_mode = MODE_HEX_RUN;
                    end else begin
                        rec      = 1'b1;
                        rec_kind = CAT_HEX_EMPTY;
                    end
                end
                MODE_HEX_RUN: begin
                    if (!is_hex) begin
                        if (r_char == CH_BSLASH) begin
                            n_mode = MODE_BSLASH;
                            n_esc  = r_pos;
                        end else begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                end
                MODE_UCN: begin
                    n_ucn_bad = r_ucn_bad | ~is_hex;
                    if (r_digits != 4'd0) begin
                        n_digits = r_digits - 4'd1;
                    end
                    if (r_digits <= 4'd1) begin
                        if (n_ucn_bad) begin
                            rec      = 1'b1;
                            rec_kind = CAT_UCN_BAD;
                        end else begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_DONE;
                end
            endcase
            if (r_pos < POS_LIMIT) begin
                n_pos = r_pos + 12'd1;
            end
        end

        // end of body: open escapes become violations
        if (ends_body && !rec) begin
            case (n_mode)
                MODE_BSLASH: begin
                    rec      = 1'b1;
                    rec_kind = CAT_TRAILING;
                end
                MODE_HEX_FIRST: begin
                    rec      = 1'b1;
                    rec_kind = CAT_HEX_EMPTY;
                end
                MODE_UCN: begin
                    rec      = 1'b1;
                    rec_kind = CAT_UCN_SHORT;
                end
                default: begin
                end
            endcase
        end

        if (rec) begin
            n_mode = MODE_DONE;
            if (!r_seen) begin
                n_seen = 1'b1;
                n_kind = rec_kind;
                n_vofs = n_esc;
            end
        end

        if (ends_body) begin
            n_found   = n_seen;
            n_cat     = n_seen ? n_kind : 3'd0;
            n_ofs     = n_seen ? n_vofs : 12'd0;
            n_mode    = MODE_NORMAL;
            n_digits  = 4'd0;
            n_ucn_bad = 1'b0;
            n_pos     = 12'd0;
            n_esc     = 12'd0;
            n_seen    = 1'b0;
            n_kind    = CAT_TRAILING;
            n_vofs    = 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_NORMAL;
            r_digits    <= 4'd0;
            r_ucn_bad   <= 1'b0;
            r_pos       <= 12'd0;
            r_esc       <= 12'd0;
            r_seen      <= 1'b0;
            r_kind      <= CAT_TRAILING;
            r_vofs      <= 12'd0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_mode    <= n_mode;
                r_digits  <= n_digits;
                r_ucn_bad <= n_ucn_bad;
                r_pos     <= n_pos;
                r_esc     <= n_esc;
                r_seen    <= n_seen;
                r_kind    <= n_kind;
                r_vofs    <= n_vofs;
            end
            if (advance && ends_body) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char    <= i_char_in;
            r_last    <= i_last;
            r_no_char <= i_no_char;
        end
        if (advance && ends_body) begin
            r_found <= n_found;
            r_cat   <= n_cat;
            r_ofs   <= n_ofs;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_category = r_cat;
    assign o_offset   = r_ofs;

endmodule

// ===== tb/sv/c_escape_sequence_validator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_escape_sequence_validator_tb
// Sends literal bodies through the escape validator: a few hand-picked
// bodies, one long body with a late backslash, then random bodies built
// mostly from well-formed escapes. Every verdict is compared with a
// behavioural scanner of the escape rules. Both channels idle at random, the
// result side holds off once for a long stretch, and the sender pauses once
// until every verdict is back.
// ----------------------------------------------------------------------------
module c_escape_sequence_validator_tb
    import cesv_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned LONG_BODY   = 200;

    typedef struct packed {
        logic        found;
        logic [2:0]  category;
        logic [11:0] offset;
    } t_verdict;

    class escape_checker;
        t_mode       mode        = MODE_NORMAL;
        logic [3:0]  digits_left = '0;
        logic        ucn_bad     = 1'b0;
        logic [11:0] pos         = '0;
        logic [11:0] esc_at      = '0;
        logic        seen        = 1'b0;
        t_cat        kind        = CAT_TRAILING;
        logic [11:0] seen_at     = '0;
        t_verdict    verdicts_due[$];
        int unsigned errors      = 0;

        static function bit is_oct(logic [7:0] c);
            return c >= CH_0 && c <= CH_7;
        endfunction

        static function bit is_hex(logic [7:0] c);
            return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
                   (c >= CH_UA && c <= CH_UF);
        endfunction

        function void clear();
            mode        = MODE_NORMAL;
            digits_left = '0;
            ucn_bad     = 1'b0;
            pos         = '0;
            esc_at      = '0;
            seen        = 1'b0;
            kind        = CAT_TRAILING;
            seen_at     = '0;
        endfunction

        // only the first violation of a body counts
        function void flag(t_cat k);
            if (!seen) begin
                seen    = 1'b1;
                kind    = k;
                seen_at = esc_at;
            end
            mode = MODE_DONE;
        endfunction

        function void plain(logic [7:0] c);
            if (c == CH_BSLASH) begin
                mode   = MODE_BSLASH;
                esc_at = pos;
            end else begin
                mode = MODE_NORMAL;
            end
        endfunction

        function void scan_byte(logic [7:0] c);
            case (mode)
                MODE_NORMAL: plain(c);
                MODE_BSLASH: begin
                    case (c)
                        CH_LN, CH_LT, CH_LV, CH_LB, CH_LR, CH_LF, CH_LA,
                        CH_BSLASH, CH_QMARK, CH_SQUOTE, CH_DQUOTE: mode = MODE_NORMAL;
                        CH_LX: mode = MODE_HEX_FIRST;
                        CH_LU, CH_UU: begin
                            mode        = MODE_UCN;
                            digits_left = (c == CH_LU) ? UCN_SHORT_DIGITS : UCN_LONG_DIGITS;
                            ucn_bad     = 1'b0;
                        end
                        default: begin
                            if (is_oct(c)) begin
                                mode        = MODE_OCTAL;
                                digits_left = OCT_MORE_DIGITS;
                            end else begin
                                flag(CAT_UNDEFINED);
                            end
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (digits_left != 0 && is_oct(c)) begin
                        digits_left = digits_left - 4'd1;
                        if (digits_left == 0)
                            mode = MODE_NORMAL;
                    end else begin
                        digits_left = '0;
                        plain(c);
                    end
                end
                MODE_HEX_FIRST: begin
                    if (is_hex(c))
                        mode = MODE_HEX_RUN;
                    else
                        flag(CAT_HEX_EMPTY);
                end
                MODE_HEX_RUN: begin
                    if (!is_hex(c))
                        plain(c);
                end
                MODE_UCN: begin
                    if (!is_hex(c))
                        ucn_bad = 1'b1;
                    if (digits_left != 0)
                        digits_left = digits_left - 4'd1;
                    if (digits_left == 0) begin
                        if (ucn_bad)
                            flag(CAT_UCN_BAD);
                        else
                            mode = MODE_NORMAL;
                    end
                end
                default: mode = MODE_DONE;
            endcase
            if (pos < POS_LIMIT)
                pos = pos + 12'd1;
        endfunction

        function void take_item(logic [7:0] ch, logic lst, logic nc);
            t_verdict v;
            if (!nc)
                scan_byte(ch);
            if (lst || nc) begin
                if (mode == MODE_BSLASH)
                    flag(CAT_TRAILING);
                else if (mode == MODE_HEX_FIRST)
                    flag(CAT_HEX_EMPTY);
                else if (mode == MODE_UCN)
                    flag(CAT_UCN_SHORT);
                v.found    = seen;
                v.category = seen ? kind : 3'd0;
                v.offset   = seen ? seen_at : 12'd0;
                verdicts_due.push_back(v);
                clear();
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_verdict(logic found, logic [2:0] category, logic [11:0] offset);
            t_verdict v;
            if (verdicts_due.size() == 0) begin
                report($sformatf("verdict with none due: found %0b category %0d offset %0d",
                                 found, category, offset));
                return;
            end
            v = verdicts_due.pop_front();
            if (found !== v.found)
                report($sformatf("found %b, expected %b", found, v.found));
            if (category !== v.category)
                report($sformatf("category %0d, expected %0d", category, v.category));
            if (offset !== v.offset)
                report($sformatf("offset %0d, expected %0d", offset, v.offset));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        i_last;
    logic        i_no_char;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [2:0]  o_category;
    logic [11:0] o_offset;

    escape_checker chk = new;
    logic [7:0]    body[$];
    logic [7:0]    simple_esc [0:10] = '{CH_LN, CH_LT, CH_LV, CH_LB, CH_LR, CH_LF, CH_LA,
                                         CH_BSLASH, CH_QMARK, CH_SQUOTE, CH_DQUOTE};
    int unsigned   items_sent  = 0;
    int unsigned   cycle_count = 0;
    bit            idle_on     = 1'b0;
    bit            hold_req    = 1'b0;

    c_escape_sequence_validator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_in  (i_char_in),
        .i_last     (i_last),
        .i_no_char  (i_no_char),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_category (o_category),
        .o_offset   (o_offset)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // result side: long hold-off on request, otherwise random stall bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            chk.check_verdict(o_found, o_category, o_offset);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] rand_hex_digit();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return CH_0 + 8'(r);
        if (r < 16)
            return CH_LA + 8'(r - 10);
        return CH_UA + 8'(r - 16);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (escape_checker::is_hex(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_BSLASH);
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_item(input logic [7:0] ch, input logic lst, input logic nc);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= ch;
        i_last    <= lst;
        i_no_char <= nc;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        chk.take_item(ch, lst, nc);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_body(input bit end_none);
        for (int k = 0; k < body.size(); k++)
            drive_item(body[k], !end_none && k == body.size() - 1, 1'b0);
        if (end_none || body.size() == 0)
            drive_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic build_random_body(output bit end_none);
        int unsigned nseg;
        int unsigned kind;
        int unsigned n;
        int unsigned bad;
        bit          stop;
        body.delete();
        end_none = ($urandom_range(0, 3) == 0);
        stop     = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n)
                body.push_back($urandom_range(0, 3) == 0 ? CH_BSLASH
                                                         : 8'($urandom_range(0, 255)));
            return;
        end
        nseg = $urandom_range(0, 6);
        for (int s = 0; s < nseg && !stop; s++) begin
            kind = $urandom_range(0, 19);
            if (kind <= 5) begin
                repeat ($urandom_range(1, 3))
                    body.push_back(rand_plain());
            end else begin
                body.push_back(CH_BSLASH);
                if (kind <= 8) begin
                    body.push_back(simple_esc[$urandom_range(0, 10)]);
                end else if (kind <= 10) begin
                    repeat ($urandom_range(1, 3))
                        body.push_back(CH_0 + 8'($urandom_range(0, 7)));
                end else if (kind <= 12) begin
                    body.push_back(CH_LX);
                    repeat ($urandom_range(1, 3))
                        body.push_back(rand_hex_digit());
                end else if (kind <= 15) begin
                    n = $urandom_range(0, 1) ? 4 : 8;
                    body.push_back(n == 4 ? CH_LU : CH_UU);
                    bad = (kind == 15) ? $urandom_range(0, n - 1) : n;
                    for (int d = 0; d < n; d++)
                        body.push_back(d == bad ? rand_non_hex() : rand_hex_digit());
                end else if (kind == 16) begin
                    n = $urandom_range(0, 1) ? 4 : 8;
                    body.push_back(n == 4 ? CH_LU : CH_UU);
                    repeat ($urandom_range(0, n - 1))
                        body.push_back(rand_hex_digit());
                    stop = 1'b1;
                end else if (kind == 17) begin
                    body.push_back(CH_LX);
                    body.push_back(rand_non_hex());
                end else if (kind == 18) begin
                    body.push_back(8'($urandom_range(0, 255)));
                end else begin
                    stop = 1'b1;
                end
            end
        end
    endtask

    initial begin
        int unsigned start;
        bit          end_none;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_char_in = '0;
        i_last    = 1'b0;
        i_no_char = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        body.delete();
        send_body(1'b1);
        body = '{CH_BSLASH};
        send_body(1'b0);
        body = '{CH_BSLASH, CH_LX};
        send_body(1'b0);
        body = '{CH_BSLASH, CH_LX, CH_LU};
        send_body(1'b0);
        body = '{CH_BSLASH, CH_UU, CH_0, CH_LA, CH_UF};
        send_body(1'b0);
        body = '{CH_BSLASH, CH_LU, CH_9, CH_LU, CH_LF, CH_7};
        send_body(1'b0);
        body = '{CH_BSLASH, CH_7, CH_BSLASH, CH_9};
        send_body(1'b0);
        body = '{8'h00, 8'hff};
        send_body(1'b1);

        // backslash late in a long body
        body.delete();
        repeat (LONG_BODY)
            body.push_back(rand_plain());
        body.push_back(CH_BSLASH);
        body.push_back(CH_9);
        body.push_back(rand_plain());
        send_body(1'b0);

        start = items_sent;
        while (items_sent - start < 600) begin
            build_random_body(end_none);
            send_body(end_none);
        end

        // fill the block while results are held back, then drain
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (i % 2)
                body = '{CH_BSLASH, CH_9};
            else
                body = '{rand_plain(), CH_BSLASH};
            send_body(1'b0);
        end
        i_valid <= 1'b0;
        while (chk.verdicts_due.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
        idle_on = 1'b1;

        start = items_sent;
        while (items_sent - start < 600) begin
            build_random_body(end_none);
            send_body(end_none);
        end
        idle_on = 1'b0;
        start = items_sent;
        while (items_sent - start < 400) begin
            build_random_body(end_none);
            send_body(end_none);
        end
        i_valid <= 1'b0;

        while (chk.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (chk.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
